### rtl/tmavg_pkg.sv
`default_nettype none
package tmavg_pkg;

	localparam int WINDOW_MAX = 64;
	localparam int SAMPLE_W   = 16;
	localparam int SIZE_W     = 7;
	localparam int SUM_W      = 22;
	localparam int PTR_W      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int N_W        = $clog2(WINDOW_MAX + 1);
	localparam int CNT_W      = $clog2(SUM_W + 1);
	localparam int PROD_W     = SUM_W + N_W + 1;

	localparam logic [SUM_W-1:0] SAT_POS = SUM_W'((2 ** (SAMPLE_W - 1)) - 1);
	localparam logic [SUM_W-1:0] SAT_NEG = SUM_W'(2 ** (SAMPLE_W - 1));

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [SUM_W-1:0]    sum_t;
	typedef logic [N_W-1:0]             wsize_t;
	typedef logic [PTR_W-1:0]           ptr_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_DIV,
		ST_FINISH
	} state_t;

	// Zero counts as one, anything above the window depth counts as the depth.
	function automatic wsize_t effective_size(input logic [SIZE_W-1:0] raw);
		wsize_t n;
		if (raw == '0) begin
			n = N_W'(1);
		end else if (32'(raw) > WINDOW_MAX) begin
			n = N_W'(WINDOW_MAX);
		end else begin
			n = N_W'(raw);
		end
		return n;
	endfunction

endpackage
`default_nettype wire

### rtl/tmavg_if.sv
`default_nettype none
interface tmavg_item_if;
	logic                 valid;
	logic                 ready;
	tmavg_pkg::sample_t   sample;
	logic                 first;

	modport source (output valid, output sample, output first, input ready);
	modport sink   (input valid, input sample, input first, output ready);
endinterface

interface tmavg_result_if;
	logic                 valid;
	logic                 ready;
	tmavg_pkg::sample_t   average;

	modport source (output valid, output average, input ready);
	modport sink   (input valid, input average, output ready);
endinterface

interface tmavg_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [tmavg_pkg::SIZE_W-1:0]      win_len;

	modport source (output valid, output win_len, input ready);
	modport sink   (input valid, input win_len, output ready);
endinterface
`default_nettype wire

### rtl/tmavg_ram.sv
`default_nettype none
module tmavg_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  wire                                      clk,
	input  wire                                      we,
	input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire  [WIDTH-1:0]                         wdata,
	input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

### rtl/trailing_moving_average.sv
`default_nettype none
// Trailing boxcar average of a signed 16-bit series, one result per sample.
// Each accepted sample passes through a window update, a bit-serial divide by
// the window size and a sign fix with saturation; a new sample is taken only
// once the previous result has been loaded into the output register.
// Reset clears the sequencer, slot pointer, running sum and fill marks and
// sets the window length to 1; the window memory itself is not cleared.
module trailing_moving_average (
	input  wire                     clk,
	input  wire                     arst_n,
	tmavg_item_if.sink              item,
	tmavg_result_if.source          result,
	tmavg_cfg_if.sink               cfg
);

	tmavg_pkg::state_t                state_q, state_d;

	logic [tmavg_pkg::SIZE_W-1:0]     win_len_q;
	tmavg_pkg::ptr_t                  slot_pointer_q;
	tmavg_pkg::sum_t                  window_sum_q;
	logic [tmavg_pkg::WINDOW_MAX-1:0] written_q;
	tmavg_pkg::sample_t               fill_q;

	tmavg_pkg::sample_t               sample_q;
	logic                             first_q;
	tmavg_pkg::wsize_t                n_q;
	tmavg_pkg::ptr_t                  slot_q;

	logic [tmavg_pkg::SUM_W-1:0]      dvd_q;
	logic [tmavg_pkg::N_W-1:0]        rem_q;
	logic [tmavg_pkg::CNT_W-1:0]      cnt_q;
	logic                             neg_q;

	logic                             res_valid_q;
	tmavg_pkg::sample_t               average_q;

	logic                             item_acc;
	logic                             res_load;
	logic                             ram_we;
	tmavg_pkg::wsize_t                n_eff;
	tmavg_pkg::ptr_t                  slot_sel;
	logic [tmavg_pkg::SAMPLE_W-1:0]   ram_rdata;
	tmavg_pkg::sample_t               old_val;
	tmavg_pkg::sum_t                  sum_step;
	logic signed [tmavg_pkg::PROD_W-1:0] fill_prod;
	tmavg_pkg::sum_t                  sum_next;
	logic [tmavg_pkg::SUM_W-1:0]      sum_abs;
	logic [tmavg_pkg::N_W:0]          slot_inc;
	tmavg_pkg::ptr_t                  ptr_next;
	logic [tmavg_pkg::N_W:0]          rem_shift;
	logic                             rem_ge;
	tmavg_pkg::sample_t               average_d;

	assign cfg.ready    = 1'b1;
	assign item.ready   = (state_q == tmavg_pkg::ST_IDLE);
	assign result.valid = res_valid_q;
	assign result.average = average_q;

	assign item_acc = item.valid && item.ready;

	// slot selection at accept time so the memory read lands in the update cycle
	assign n_eff = tmavg_pkg::effective_size(win_len_q);
	always_comb begin
		if (item.first) begin
			slot_sel = '0;
		end else if (tmavg_pkg::N_W'(slot_pointer_q) < n_eff) begin
			slot_sel = slot_pointer_q;
		end else begin
			slot_sel = '0;
		end
	end

	tmavg_ram #(
		.WIDTH(tmavg_pkg::SAMPLE_W),
		.DEPTH(tmavg_pkg::WINDOW_MAX)
	) u_window (
		.clk   (clk),
		.we    (ram_we),
		.waddr (slot_q),
		.wdata (sample_q),
		.raddr (slot_sel),
		.rdata (ram_rdata)
	);

	// entries not written since the last first sample hold the fill value
	assign old_val  = written_q[slot_q] ? tmavg_pkg::sample_t'(ram_rdata) : fill_q;
	assign sum_step = window_sum_q + tmavg_pkg::SUM_W'(sample_q)
	                  - tmavg_pkg::SUM_W'(old_val);
	assign fill_prod = tmavg_pkg::PROD_W'(sample_q) * $signed({1'b0, n_q});
	assign sum_next = first_q ? tmavg_pkg::sum_t'(fill_prod[tmavg_pkg::SUM_W-1:0]) : sum_step;
	assign sum_abs  = sum_next[tmavg_pkg::SUM_W-1] ? -sum_next : sum_next;

	assign slot_inc = {1'b0, tmavg_pkg::N_W'(slot_q)} + (tmavg_pkg::N_W + 1)'(1);
	assign ptr_next = (slot_inc >= {1'b0, n_q}) ? '0
	                  : slot_inc[tmavg_pkg::PTR_W-1:0];

	// one restoring divide step
	assign rem_shift = {rem_q, dvd_q[tmavg_pkg::SUM_W-1]};
	assign rem_ge    = (rem_shift >= {1'b0, n_q});

	always_comb begin
		if (neg_q) begin
			average_d = (dvd_q > tmavg_pkg::SAT_NEG) ? tmavg_pkg::sample_t'(tmavg_pkg::SAT_NEG)
			            : tmavg_pkg::sample_t'(-dvd_q);
		end else begin
			average_d = (dvd_q > tmavg_pkg::SAT_POS) ? tmavg_pkg::sample_t'(tmavg_pkg::SAT_POS)
			            : tmavg_pkg::sample_t'(dvd_q);
		end
	end

	always_comb begin
		state_d  = state_q;
		ram_we   = 1'b0;
		res_load = 1'b0;
		unique case (state_q)
			tmavg_pkg::ST_IDLE: begin
				if (item_acc) begin
					state_d = tmavg_pkg::ST_UPDATE;
				end
			end
			tmavg_pkg::ST_UPDATE: begin
				ram_we  = !first_q;
				state_d = tmavg_pkg::ST_DIV;
			end
			tmavg_pkg::ST_DIV: begin
				if (cnt_q == tmavg_pkg::CNT_W'(tmavg_pkg::SUM_W - 1)) begin
					state_d = tmavg_pkg::ST_FINISH;
				end
			end
			tmavg_pkg::ST_FINISH: begin
				// hold until the output register is free
				if (!res_valid_q || result.ready) begin
					res_load = 1'b1;
					state_d  = tmavg_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tmavg_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tmavg_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_len_q      <= tmavg_pkg::SIZE_W'(1);
			slot_pointer_q <= '0;
			window_sum_q   <= '0;
			written_q      <= '0;
			fill_q         <= '0;
			res_valid_q    <= 1'b0;
		end else begin
			if (cfg.valid) begin
				win_len_q <= cfg.win_len;
			end
			if (state_q == tmavg_pkg::ST_UPDATE) begin
				window_sum_q   <= sum_next;
				slot_pointer_q <= ptr_next;
				if (first_q) begin
					written_q <= '0;
					fill_q    <= sample_q;
				end else begin
					written_q[slot_q] <= 1'b1;
				end
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_acc) begin
			sample_q <= item.sample;
			first_q  <= item.first;
			n_q      <= n_eff;
			slot_q   <= slot_sel;
		end
		if (state_q == tmavg_pkg::ST_UPDATE) begin
			dvd_q <= sum_abs;
			rem_q <= '0;
			cnt_q <= '0;
			neg_q <= sum_next[tmavg_pkg::SUM_W-1];
		end else if (state_q == tmavg_pkg::ST_DIV) begin
			dvd_q <= {dvd_q[tmavg_pkg::SUM_W-2:0], rem_ge};
			rem_q <= rem_ge ? tmavg_pkg::N_W'(rem_shift - {1'b0, n_q})
			         : rem_shift[tmavg_pkg::N_W-1:0];
			cnt_q <= cnt_q + tmavg_pkg::CNT_W'(1);
		end
		if (res_load) begin
			average_q <= average_d;
		end
	end

endmodule
`default_nettype wire
